// ----- hw/rtl/q2e_pkg.sv -----
`default_nettype none

package q2e_pkg;

    // angle accumulator: 2^-20 degree
    localparam int unsigned ACC_BITS = 20;
    localparam logic signed [31:0] DEG90 = 32'sd94371840;
    // pole threshold on s, Q30
    localparam logic signed [35:0] POLE_S = 36'sd1073527076;
    // ceil(2^31 / 131), exact for every gyro magnitude
    localparam logic [24:0] RATE_MUL = 25'd16393005;
    localparam logic [22:0] RATE_BIAS = 23'd65;

    // cordic vector: x, y in Q30 with headroom, z in 2^-20 degree
    typedef struct packed {
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic signed [31:0] z;
        logic               zero;
    } t_cvec;

    typedef struct packed {
        logic signed [34:0] pxz;
        logic signed [34:0] pwy;
        logic signed [34:0] pxw;
        logic signed [34:0] pyz;
        logic signed [34:0] pzz;
        logic signed [34:0] pww;
        logic signed [34:0] pxy;
        logic signed [34:0] pzw;
        logic signed [34:0] pyy;
        logic signed [31:0] qw;
        logic signed [31:0] qy;
        logic [22:0]        m0;
        logic [22:0]        m1;
        logic [22:0]        m2;
        logic               ng0;
        logic               ng1;
        logic               ng2;
        logic [15:0]        rt0;
        logic [15:0]        rt1;
        logic [15:0]        rt2;
        logic signed [35:0] s;
        logic               pole_hi;
        logic               pole_lo;
        t_cvec              cr;
        t_cvec              cy;
        t_cvec              cp;
        logic [63:0]        rad;
        logic [35:0]        rem;
        logic [31:0]        root;
        logic [15:0]        yaw_o;
        logic [14:0]        pit_o;
        logic [16:0]        roll_o;
    } t_pipe;

    // atan(2^-i) in 2^-20 degree
    function automatic logic signed [31:0] f_atan(input int unsigned i);
        logic signed [31:0] v;
        case (i)
            0:  v = 32'sd47185920;
            1:  v = 32'sd27855475;
            2:  v = 32'sd14718068;
            3:  v = 32'sd7471121;
            4:  v = 32'sd3750058;
            5:  v = 32'sd1876857;
            6:  v = 32'sd938658;
            7:  v = 32'sd469357;
            8:  v = 32'sd234682;
            9:  v = 32'sd117342;
            10: v = 32'sd58671;
            11: v = 32'sd29335;
            12: v = 32'sd14668;
            13: v = 32'sd7334;
            14: v = 32'sd3667;
            15: v = 32'sd1833;
            16: v = 32'sd917;
            17: v = 32'sd458;
            18: v = 32'sd229;
            19: v = 32'sd115;
            20: v = 32'sd57;
            21: v = 32'sd29;
            22: v = 32'sd14;
            23: v = 32'sd7;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // quarter turn into the right half plane, zero vector flagged
    function automatic t_cvec f_pre(input logic signed [39:0] y, input logic signed [39:0] x);
        t_cvec v;
        v.x    = x;
        v.y    = y;
        v.z    = '0;
        v.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            if (y >= 0) begin
                v.x = y;
                v.y = -x;
                v.z = DEG90;
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -DEG90;
            end
        end
        return v;
    endfunction

    // one vectoring micro-rotation
    function automatic t_cvec f_iter(input t_cvec v, input int unsigned i);
        t_cvec r;
        logic signed [39:0] dx;
        logic signed [39:0] dy;
        dx = v.y >>> i;
        dy = v.x >>> i;
        r  = v;
        if (v.y >= 0) begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + f_atan(i);
        end else begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - f_atan(i);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/quaternion_to_euler_degrees.sv -----
`default_nettype none

// quaternion to euler angles with gyro rate scaling
//
// slave channel (i_s_*): one motion packet per word, four q30 quaternion
// components and three raw gyro samples. master channel (o_m_*): one result
// word per packet, yaw, pitch and roll in 1/2^ANGLE_FRAC_BITS degree and the
// three gyro rates (reordered z, y, x) in 1/128 deg/s.
//
// stages: products, sums, square, 16 isqrt stages of two root bits,
// quarter-turn stage, one cordic stage per micro-rotation, output rounding;
// o_m_tvalid is the valid bit of the output rounding stage.
// throughput: one packet per cycle while the pipe is not stalled full; the
// cordic and isqrt stages are fully pipelined and every packet stands alone.
//
// each stage holds a valid bit and moves whenever the stage after it is
// empty or moving, so bubbles collapse and a stalled output holds its word
// while earlier stages keep filling. o_s_tready drops only when every stage
// is full and the receiver holds i_m_tready low.
// reset (i_rst_n low, synchronous) empties the pipe; no result is pending.
module quaternion_to_euler_degrees #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int CORDIC_STAGES   = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // quat_w, quat_x, quat_y, quat_z, gyro_raw_x, gyro_raw_y, gyro_raw_z
    input  wire logic [175:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // yaw_angle, pitch_angle, roll_angle, rate_out0, rate_out1, rate_out2
    output logic [95:0]       o_m_tdata
);

    localparam int ISQ_STAGES = 16;
    localparam int K_ISQ0     = 3;
    localparam int K_PRE      = K_ISQ0 + ISQ_STAGES;
    localparam int K_COR0     = K_PRE + 1;
    localparam int K_OUT      = K_COR0 + CORDIC_STAGES;
    localparam int NUM_ST     = K_OUT + 1;
    localparam int RND_SH     = q2e_pkg::ACC_BITS - ANGLE_FRAC_BITS;

    q2e_pkg::t_pipe r_pipe [NUM_ST];
    q2e_pkg::t_pipe n_pipe [NUM_ST];
    logic [NUM_ST-1:0] r_vld;
    logic [NUM_ST:0]   w_adv;

    // a stage loads when it is empty or its word moves on
    assign w_adv[NUM_ST] = i_m_tready;

    genvar k;
    generate
        for (k = 0; k < NUM_ST; k++) begin : g_st
            assign w_adv[k] = !r_vld[k] || w_adv[k+1];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_s_tvalid : r_vld[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_adv[k]) begin
                    r_pipe[k] <= n_pipe[k];
                end
            end

            if (k == 0) begin : g_prod
                // doubled products, floor(a*b / 2^29)
                always_comb begin
                    logic signed [31:0] qw, qx, qy, qz;
                    logic signed [63:0] pxz, pwy, pxw, pyz, pzz, pww, pxy, pzw, pyy;
                    logic signed [22:0] g0, g1, g2;
                    qw  = i_s_tdata[31:0];
                    qx  = i_s_tdata[63:32];
                    qy  = i_s_tdata[95:64];
                    qz  = i_s_tdata[127:96];
                    pxz = qx * qz;
                    pwy = qw * qy;
                    pxw = qx * qw;
                    pyz = qy * qz;
                    pzz = qz * qz;
                    pww = qw * qw;
                    pxy = qx * qy;
                    pzw = qz * qw;
                    pyy = qy * qy;
                    // raw * 128, rate_out0 from axis 2
                    g0 = {{7{i_s_tdata[175]}}, i_s_tdata[175:160]} <<< 7;
                    g1 = {{7{i_s_tdata[159]}}, i_s_tdata[159:144]} <<< 7;
                    g2 = {{7{i_s_tdata[143]}}, i_s_tdata[143:128]} <<< 7;
                    n_pipe[k]     = '0;
                    n_pipe[k].pxz = pxz[63:29];
                    n_pipe[k].pwy = pwy[63:29];
                    n_pipe[k].pxw = pxw[63:29];
                    n_pipe[k].pyz = pyz[63:29];
                    n_pipe[k].pzz = pzz[63:29];
                    n_pipe[k].pww = pww[63:29];
                    n_pipe[k].pxy = pxy[63:29];
                    n_pipe[k].pzw = pzw[63:29];
                    n_pipe[k].pyy = pyy[63:29];
                    n_pipe[k].qw  = qw;
                    n_pipe[k].qy  = qy;
                    n_pipe[k].ng0 = g0[22];
                    n_pipe[k].ng1 = g1[22];
                    n_pipe[k].ng2 = g2[22];
                    n_pipe[k].m0  = (g0[22] ? 23'(-g0) : 23'(g0)) + q2e_pkg::RATE_BIAS;
                    n_pipe[k].m1  = (g1[22] ? 23'(-g1) : 23'(g1)) + q2e_pkg::RATE_BIAS;
                    n_pipe[k].m2  = (g2[22] ? 23'(-g2) : 23'(g2)) + q2e_pkg::RATE_BIAS;
                end
            end else if (k == 1) begin : g_sum
                // trig arguments, pole test, rate reciprocal multiply
                always_comb begin
                    logic signed [39:0] one;
                    logic signed [39:0] ry, rx, yy, yx;
                    logic [47:0] q0, q1, q2;
                    logic hi, lo;
                    one = 40'sd1 <<< 30;
                    n_pipe[k]   = r_pipe[k-1];
                    n_pipe[k].s = 36'(r_pipe[k-1].pxz) - 36'(r_pipe[k-1].pwy);
                    hi = n_pipe[k].s >= q2e_pkg::POLE_S;
                    lo = n_pipe[k].s <= -q2e_pkg::POLE_S;
                    ry = 40'(r_pipe[k-1].pxw) + 40'(r_pipe[k-1].pyz);
                    rx = one - (40'(r_pipe[k-1].pzz) + 40'(r_pipe[k-1].pww));
                    yy = 40'(r_pipe[k-1].pxy) - 40'(r_pipe[k-1].pzw);
                    yx = one - (40'(r_pipe[k-1].pyy) + 40'(r_pipe[k-1].pzz));
                    n_pipe[k].pole_hi = hi;
                    n_pipe[k].pole_lo = lo;
                    // at a pole roll comes from atan2(y, w)
                    n_pipe[k].cr   = '0;
                    n_pipe[k].cr.x = (hi || lo) ? 40'(r_pipe[k-1].qw) : rx;
                    n_pipe[k].cr.y = (hi || lo) ? 40'(r_pipe[k-1].qy) : ry;
                    n_pipe[k].cy   = '0;
                    n_pipe[k].cy.x = yx;
                    n_pipe[k].cy.y = yy;
                    q0 = 48'(r_pipe[k-1].m0) * 48'(q2e_pkg::RATE_MUL);
                    q1 = 48'(r_pipe[k-1].m1) * 48'(q2e_pkg::RATE_MUL);
                    q2 = 48'(r_pipe[k-1].m2) * 48'(q2e_pkg::RATE_MUL);
                    n_pipe[k].rt0 = r_pipe[k-1].ng0 ? 16'(-q0[47:31]) : 16'(q0[47:31]);
                    n_pipe[k].rt1 = r_pipe[k-1].ng1 ? 16'(-q1[47:31]) : 16'(q1[47:31]);
                    n_pipe[k].rt2 = r_pipe[k-1].ng2 ? 16'(-q2[47:31]) : 16'(q2[47:31]);
                end
            end else if (k == 2) begin : g_sq
                // cos^2 = 1 - s^2; away from the poles s fits 31 bits
                always_comb begin
                    logic signed [30:0] sn;
                    logic signed [61:0] sq;
                    sn = r_pipe[k-1].s[30:0];
                    sq = sn * sn;
                    n_pipe[k]      = r_pipe[k-1];
                    n_pipe[k].rad  = (64'd1 << 60) - 64'(unsigned'(sq));
                    n_pipe[k].rem  = '0;
                    n_pipe[k].root = '0;
                end
            end else if (k < K_PRE) begin : g_isq
                // two root bits per stage
                always_comb begin
                    logic [63:0] rad;
                    logic [35:0] rem, remt, trial;
                    logic [31:0] root;
                    rad  = r_pipe[k-1].rad;
                    rem  = r_pipe[k-1].rem;
                    root = r_pipe[k-1].root;
                    for (int j = 0; j < 2; j++) begin
                        remt  = {rem[33:0], rad[63:62]};
                        rad   = rad << 2;
                        trial = {2'b00, root, 2'b01};
                        if (remt >= trial) begin
                            rem  = remt - trial;
                            root = {root[30:0], 1'b1};
                        end else begin
                            rem  = remt;
                            root = {root[30:0], 1'b0};
                        end
                    end
                    n_pipe[k]      = r_pipe[k-1];
                    n_pipe[k].rad  = rad;
                    n_pipe[k].rem  = rem;
                    n_pipe[k].root = root;
                end
            end else if (k == K_PRE) begin : g_pre
                always_comb begin
                    n_pipe[k]    = r_pipe[k-1];
                    n_pipe[k].cr = q2e_pkg::f_pre(r_pipe[k-1].cr.y, r_pipe[k-1].cr.x);
                    n_pipe[k].cy = q2e_pkg::f_pre(r_pipe[k-1].cy.y, r_pipe[k-1].cy.x);
                    n_pipe[k].cp = q2e_pkg::f_pre(40'(r_pipe[k-1].s),
                                                  40'(unsigned'(r_pipe[k-1].root)));
                end
            end else if (k < K_OUT) begin : g_cor
                always_comb begin
                    n_pipe[k]    = r_pipe[k-1];
                    n_pipe[k].cr = q2e_pkg::f_iter(r_pipe[k-1].cr, k - K_COR0);
                    n_pipe[k].cy = q2e_pkg::f_iter(r_pipe[k-1].cy, k - K_COR0);
                    n_pipe[k].cp = q2e_pkg::f_iter(r_pipe[k-1].cp, k - K_COR0);
                end
            end else begin : g_out
                // pole override, then round to output resolution
                always_comb begin
                    logic signed [33:0] zr, zy, zp, ar, ay, ap, half;
                    logic pole;
                    pole = r_pipe[k-1].pole_hi || r_pipe[k-1].pole_lo;
                    half = 34'sd1 <<< (RND_SH - 1);
                    zr = r_pipe[k-1].cr.zero ? 34'sd0 : 34'(r_pipe[k-1].cr.z);
                    zy = r_pipe[k-1].cy.zero ? 34'sd0 : 34'(r_pipe[k-1].cy.z);
                    zp = r_pipe[k-1].cp.zero ? 34'sd0 : 34'(r_pipe[k-1].cp.z);
                    if (r_pipe[k-1].pole_hi) begin
                        ar = zr <<< 1;
                        ap = 34'(q2e_pkg::DEG90);
                    end else if (r_pipe[k-1].pole_lo) begin
                        ar = -(zr <<< 1);
                        ap = -34'(q2e_pkg::DEG90);
                    end else begin
                        ar = zr;
                        ap = zp;
                    end
                    ay = pole ? 34'sd0 : zy;
                    n_pipe[k]        = r_pipe[k-1];
                    n_pipe[k].roll_o = 17'((ar + half) >>> RND_SH);
                    n_pipe[k].pit_o  = 15'((ap + half) >>> RND_SH);
                    n_pipe[k].yaw_o  = 16'((ay + half) >>> RND_SH);
                end
            end
        end
    endgenerate

    assign o_s_tready = w_adv[0];
    assign o_m_tvalid = r_vld[K_OUT];
    assign o_m_tdata  = {r_pipe[K_OUT].rt2, r_pipe[K_OUT].rt1, r_pipe[K_OUT].rt0,
                         r_pipe[K_OUT].roll_o, r_pipe[K_OUT].pit_o, r_pipe[K_OUT].yaw_o};

    // input held off only when the whole pipe is full
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // an accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted word lost at pipe entry");

    // the two pole tests exclude each other
    a_pole_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> !(r_pipe[1].pole_hi && r_pipe[1].pole_lo))
        else $error("both poles flagged");

    // yaw is forced to zero at a pole
    a_pole_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[K_OUT] && (r_pipe[K_OUT].pole_hi || r_pipe[K_OUT].pole_lo))
            |-> (r_pipe[K_OUT].yaw_o == '0))
        else $error("nonzero yaw at a pole");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none

module tb;

    localparam int FRAC   = 7;
    localparam int STAGES = 16;
    localparam int LAT    = STAGES + 21;
    localparam longint DEG90_A = 64'sd94371840;
    localparam longint POLE_A  = 64'sd1073527076;
    localparam int N_RAND  = 1200;
    localparam int LIMIT   = 400000;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
    } t_packet;

    typedef struct packed {
        logic [15:0] yaw;
        logic [14:0] pitch;
        logic [16:0] roll;
        logic [15:0] r0;
        logic [15:0] r1;
        logic [15:0] r2;
    } t_angles;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [175:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [95:0]  o_m_tdata;

    quaternion_to_euler_degrees #(
        .ANGLE_FRAC_BITS(FRAC),
        .CORDIC_STAGES  (STAGES)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_packet packets_to_send[$];
    t_angles angles_due[$];
    int      errors = 0;
    int      cycles = 0;
    bit      feeding_done = 1'b0;
    int      hold_left = 0;
    bit      hold_done = 1'b0;

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint dbl_prod(longint a, longint b);
        return floor_shift(a * b, 29);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint atan_step(int i);
        longint tab[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                            938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334,
                            3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
        return tab[i];
    endfunction

    // vectoring cordic, angle in 2^-20 degree
    function automatic longint vec_atan2(longint y, longint x);
        longint acc, t, dx, dy;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; acc = DEG90_A;
            end else begin
                x = -y; y = t; acc = -DEG90_A;
            end
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; acc += atan_step(i);
            end else begin
                x -= dx; y += dy; acc -= atan_step(i);
            end
        end
        return acc;
    endfunction

    function automatic longint to_degrees(longint a);
        int k;
        k = 20 - FRAC;
        return floor_shift(a + (64'sd1 << (k - 1)), k);
    endfunction

    function automatic longint gyro_rate(longint raw);
        longint n;
        n = raw * 128;
        if (n >= 0) return (n + 65) / 131;
        return -((-n + 65) / 131);
    endfunction

    function automatic t_angles euler_of(t_packet p);
        longint w, x, y, z, s, roll, pitch, yaw;
        longint unsigned c2;
        t_angles r;
        w = p.w; x = p.x; y = p.y; z = p.z;
        s = dbl_prod(x, z) - dbl_prod(w, y);
        if (s >= POLE_A) begin
            roll = 2 * vec_atan2(y, w); pitch = DEG90_A; yaw = 0;
        end else if (s <= -POLE_A) begin
            roll = -2 * vec_atan2(y, w); pitch = -DEG90_A; yaw = 0;
        end else begin
            c2 = (64'd1 << 60) - longint'(s * s);
            roll = vec_atan2(dbl_prod(x, w) + dbl_prod(y, z),
                             (64'sd1 << 30) - (dbl_prod(z, z) + dbl_prod(w, w)));
            pitch = vec_atan2(s, int_sqrt(c2));
            yaw = vec_atan2(dbl_prod(x, y) - dbl_prod(z, w),
                            (64'sd1 << 30) - (dbl_prod(y, y) + dbl_prod(z, z)));
        end
        r.yaw   = 16'(to_degrees(yaw));
        r.pitch = 15'(to_degrees(pitch));
        r.roll  = 17'(to_degrees(roll));
        r.r0    = 16'(gyro_rate(p.gz));
        r.r1    = 16'(gyro_rate(p.gy));
        r.r2    = 16'(gyro_rate(p.gx));
        return r;
    endfunction

    function automatic logic [175:0] pack_packet(t_packet p);
        return {p.gz, p.gy, p.gx, p.z, p.y, p.x, p.w};
    endfunction

    // quat_w in the lowest bits, gyro axis 2 in the highest
    function automatic t_packet unpack_packet(logic [175:0] d);
        t_packet p;
        p.w  = d[31:0];
        p.x  = d[63:32];
        p.y  = d[95:64];
        p.z  = d[127:96];
        p.gx = d[143:128];
        p.gy = d[159:144];
        p.gz = d[175:160];
        return p;
    endfunction

    function automatic t_angles unpack_angles(logic [95:0] d);
        t_angles r;
        r.yaw   = d[15:0];
        r.pitch = d[30:16];
        r.roll  = d[47:31];
        r.r0    = d[63:48];
        r.r1    = d[79:64];
        r.r2    = d[95:80];
        return r;
    endfunction

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'sh4000_0000;
            1: return -32'sh4000_0000;
            2: return 32'($urandom);
            3: return 32'sd0;
            default: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
        endcase
    endfunction

    // unit quaternion from a random rotation, sometimes steered to a pole; sel 9 gives arbitrary components instead
    function automatic t_packet rand_packet();
        t_packet p;
        real a, b, c, d, n;
        int sel;
        sel = $urandom_range(0, 9);
        a = $itor($signed($urandom_range(0, 2000)) - 1000);
        b = $itor($signed($urandom_range(0, 2000)) - 1000);
        c = $itor($signed($urandom_range(0, 2000)) - 1000);
        d = $itor($signed($urandom_range(0, 2000)) - 1000);
        if (sel == 0) begin
            // s = 2(xz - wy) near +1 or -1: x=z, w=-y or the reverse
            c = -a; d = b;
            if ($urandom_range(0, 1)) begin c = a; d = -b; end
        end
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) begin a = 1000.0; n = 1000.0; end
        if (sel == 9) begin
            p.w = rand_comp(); p.x = rand_comp(); p.y = rand_comp(); p.z = rand_comp();
        end else begin
            p.w = $rtoi(a / n * 1073741823.0);
            p.x = $rtoi(b / n * 1073741823.0);
            p.y = $rtoi(c / n * 1073741823.0);
            p.z = $rtoi(d / n * 1073741823.0);
        end
        p.gx = 16'($urandom); p.gy = 16'($urandom); p.gz = 16'($urandom);
        return p;
    endfunction

    function automatic t_packet make_packet(int w, int x, int y, int z,
                                            int gx, int gy, int gz);
        t_packet p;
        p.w = w; p.x = x; p.y = y; p.z = z;
        p.gx = 16'(gx); p.gy = 16'(gy); p.gz = 16'(gz);
        return p;
    endfunction

    initial begin
        localparam int ONE = 32'sh4000_0000;
        localparam int H = 32'sh2000_0000;
        // identity, gyro extremes
        packets_to_send.push_back(make_packet(ONE, 0, 0, 0, -32768, 32767, 0));
        packets_to_send.push_back(make_packet(-ONE, 0, 0, 0, 32767, -32768, -1));
        // upper pole: x=z=1/2, w=-y=1/2
        packets_to_send.push_back(make_packet(H, H, -H, H, 1, -1, 131));
        // lower pole
        packets_to_send.push_back(make_packet(H, H, H, -H, -131, 65, -65));
        packets_to_send.push_back(make_packet(0, ONE, ONE, 0, 0, 0, 0));
        packets_to_send.push_back(make_packet(0, 0, 0, 0, 16, -16, 100));
        packets_to_send.push_back(make_packet(0, 0, -ONE, 0, 0, 0, 0));
        packets_to_send.push_back(make_packet(0, ONE, 0, 0, 0, 0, 0));
        packets_to_send.push_back(make_packet(0, 0, 0, ONE, 0, 0, 0));
        packets_to_send.push_back(make_packet(-1, -1, -1, -1, -1, -1, -1));
        packets_to_send.push_back(make_packet(32'h7fff_ffff, 32'h8000_0000,
                                              32'h7fff_ffff, 32'h8000_0000, 7, 8, 9));
        packets_to_send.push_back(make_packet(32'h8000_0000, 32'h8000_0000,
                                              32'h8000_0000, 32'h8000_0000, 0, 0, 0));
        packets_to_send.push_back(make_packet(-H, -H, H, -H, 1000, 2000, -3000));
        for (int i = 0; i < N_RAND; i++) packets_to_send.push_back(rand_packet());
        feeding_done = 1'b1;
    end

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) begin
                angles_due.push_back(euler_of(unpack_packet(i_s_tdata)));
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_s_tvalid <= 1'b0;
            end else if (packets_to_send.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pack_packet(packets_to_send.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: a stall pattern, interrupted once by a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (!hold_done && cycles == 300) begin
            hold_left <= 3 * LAT;
            hold_done <= 1'b1;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if ((cycles / 200) % 3 == 0) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_angles got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = unpack_angles(o_m_tdata);
            if (angles_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", o_m_tdata);
            end else begin
                want = angles_due.pop_front();
                if (got != want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch yaw %0d/%0d pitch %0d/%0d roll %0d/%0d rates %h/%h",
                                 $signed(want.yaw), $signed(got.yaw),
                                 $signed(want.pitch), $signed(got.pitch),
                                 $signed(want.roll), $signed(got.roll),
                                 {want.r0, want.r1, want.r2}, {got.r0, got.r1, got.r2});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (feeding_done);
        while (packets_to_send.size() > 0 || i_s_tvalid || angles_due.size() > 0)
            @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        if (errors == 0 && angles_due.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
